/* rtl/lcdt_pkg.sv */
// shared types and constants for the lcd line and mode timer
package lcdt_pkg;

	// field widths fixed by the item format
	localparam int LINE_W = 8;
	localparam int DELTA_W = 8;
	localparam int MODE_W = 2;
	localparam int IRQ_EN_W = 4;

	// packed stream widths
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 16;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OAM = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

	// bit positions in irq_enables
	localparam int EN_HBLANK_BIT = 0;
	localparam int EN_VBLANK_BIT = 1;
	localparam int EN_OAM_BIT = 2;
	localparam int EN_MATCH_BIT = 3;

	// one update item
	typedef struct packed {
		logic [IRQ_EN_W-1:0] irq_enables;
		logic [LINE_W-1:0]   compare_line;
		logic                lcd_enable;
		logic [DELTA_W-1:0]  cycles_delta;
	} lcdt_item_t;

	// one result item
	typedef struct packed {
		logic              render_line;
		logic              stat_irq;
		logic              vblank_irq;
		logic              coincidence;
		logic [MODE_W-1:0] mode;
		logic [LINE_W-1:0] line;
	} lcdt_result_t;

endpackage

/* rtl/lcd_line_and_mode_timer.sv */
// top level of the lcd line and mode timer with input and result registers
//
// usage:
//   s_axis carries update items: cycle delta, display enable, compare line and
//   status interrupt enables. m_axis returns one result item per update: line,
//   mode, coincidence, vblank request, status request and render-line pulse.
//   an accepted item sits in the input register, then the result register and
//   the timer state are loaded from the update logic once the result register
//   is free or being taken.
//   throughput is one item per cycle while the receiver takes results, since
//   the update path into the result register and state is combinational.
//   while the receiver stalls, the result register holds; one more item waits
//   in the input register, after which s_axis_tready drops until the result is
//   taken.
//   reset clears both valid flags, the accumulator, line and mode.
//   s_axis_tdata (lsb first): cycles_delta[7:0], lcd_enable[8],
//   compare_line[16:9], irq_enables[20:17], zero fill
//   m_axis_tdata (lsb first): line[7:0], mode[9:8], coincidence[10],
//   vblank_irq[11], stat_irq[12], render_line[13], zero fill
module lcd_line_and_mode_timer #(
	parameter int LINE_CYCLES = 456,
	parameter int TOTAL_LINES = 154,
	parameter int VISIBLE_LINES = 144,
	parameter int OAM_CYCLES = 80,
	parameter int TRANSFER_CYCLES = 172
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// cycles_delta, lcd_enable, compare_line, irq_enables, zero fill
	input  logic [lcdt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// line, mode, coincidence, vblank_irq, stat_irq, render_line, zero fill
	output logic [lcdt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import lcdt_pkg::*;

	localparam int RES_W = $bits(lcdt_result_t);

	logic         valid_s1;
	lcdt_item_t   item_s1;
	logic         out_valid_q;
	lcdt_result_t res_q;
	lcdt_result_t res_nxt;
	logic         advance;
	logic         in_fire;

	assign advance = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;
	assign in_fire = s_axis_tvalid & s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= s_axis_tdata[$bits(lcdt_item_t)-1:0];
		end
	end

	// update logic and timer state
	lcdt_step #(
		.LINE_CYCLES(LINE_CYCLES),
		.TOTAL_LINES(TOTAL_LINES),
		.VISIBLE_LINES(VISIBLE_LINES),
		.OAM_CYCLES(OAM_CYCLES),
		.TRANSFER_CYCLES(TRANSFER_CYCLES)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.update(advance),
		.item(item_s1),
		.result(res_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (~out_valid_q | m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, res_q};

endmodule

/* rtl/lcdt_step.sv */
// timer state registers and the per-item update logic
module lcdt_step #(
	parameter int LINE_CYCLES = 456,
	parameter int TOTAL_LINES = 154,
	parameter int VISIBLE_LINES = 144,
	parameter int OAM_CYCLES = 80,
	parameter int TRANSFER_CYCLES = 172
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 update,
	input  lcdt_pkg::lcdt_item_t item,
	output lcdt_pkg::lcdt_result_t result
);
	import lcdt_pkg::*;

	localparam int ACC_W = $clog2(LINE_CYCLES);
	localparam int SUM_W = ACC_W + 1;
	localparam logic [SUM_W-1:0] LC_SUM = SUM_W'(LINE_CYCLES);
	localparam logic [SUM_W-1:0] OAM_SUM = SUM_W'(OAM_CYCLES);
	localparam logic [SUM_W-1:0] HBL_SUM = SUM_W'(OAM_CYCLES + TRANSFER_CYCLES);
	localparam logic [LINE_W-1:0] TOTAL_L = LINE_W'(TOTAL_LINES);
	localparam logic [LINE_W-1:0] VISIBLE_L = LINE_W'(VISIBLE_LINES);

	logic [ACC_W-1:0]  accum_q;
	logic [LINE_W-1:0] line_q;
	logic [MODE_W-1:0] mode_q;

	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  sum_sub;
	logic              wrap;
	logic [LINE_W-1:0] line_inc;
	logic [ACC_W-1:0]  accum_nxt;
	logic [LINE_W-1:0] line_nxt;
	logic [SUM_W-1:0]  accum_ext;
	logic              match_nxt;
	logic [MODE_W-1:0] mode_nxt;
	logic              vb;
	logic              st;
	logic              rl;

	// accumulator and line advance, at most one line per item
	always_comb begin
		sum = {1'b0, accum_q} + SUM_W'(item.cycles_delta);
		sum_sub = sum - LC_SUM;
		wrap = (sum >= LC_SUM);
		line_inc = line_q + LINE_W'(1);
		if (wrap) begin
			accum_nxt = sum_sub[ACC_W-1:0];
			line_nxt = (line_inc >= TOTAL_L) ? '0 : line_inc;
		end else begin
			accum_nxt = sum[ACC_W-1:0];
			line_nxt = line_q;
		end
		accum_ext = {1'b0, accum_nxt};
		match_nxt = (line_nxt == item.compare_line);
	end

	// mode selection and entry requests
	always_comb begin
		vb = 1'b0;
		rl = 1'b0;
		st = match_nxt & item.irq_enables[EN_MATCH_BIT];
		priority if (line_nxt >= VISIBLE_L) begin
			mode_nxt = MODE_VBLANK;
			if (mode_q != MODE_VBLANK) begin
				vb = 1'b1;
				st = st | item.irq_enables[EN_VBLANK_BIT];
			end
		end else if (accum_ext >= HBL_SUM) begin
			mode_nxt = MODE_HBLANK;
			if (mode_q != MODE_HBLANK) begin
				st = st | item.irq_enables[EN_HBLANK_BIT];
			end
		end else if (accum_ext >= OAM_SUM) begin
			mode_nxt = MODE_TRANSFER;
			rl = (mode_q != MODE_TRANSFER);
		end else begin
			mode_nxt = MODE_OAM;
			if (mode_q != MODE_OAM) begin
				st = st | item.irq_enables[EN_OAM_BIT];
			end
		end
	end

	// result fields, all clear while the display is off
	// the match flag lives on as the coincidence bit of the result
	always_comb begin
		if (item.lcd_enable) begin
			result.line = line_nxt;
			result.mode = mode_nxt;
			result.coincidence = match_nxt;
			result.vblank_irq = vb;
			result.stat_irq = st;
			result.render_line = rl;
		end else begin
			result = '0;
		end
	end

	// state update, accumulator kept while the display is off, line and mode cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			line_q <= '0;
			mode_q <= MODE_HBLANK;
		end else if (update) begin
			if (item.lcd_enable) begin
				accum_q <= accum_nxt;
				line_q <= line_nxt;
				mode_q <= mode_nxt;
			end else begin
				line_q <= '0;
				mode_q <= MODE_HBLANK;
			end
		end
	end

endmodule

/* rtl/lcdt_checker.sv */
// port-level checks for the lcd line and mode timer, bound to the top level
module lcdt_checker #(
	parameter int TOTAL_LINES = 154,
	parameter int VISIBLE_LINES = 144
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic [lcdt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [lcdt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import lcdt_pkg::*;

	logic [LINE_W-1:0] line;
	logic [MODE_W-1:0] mode;
	logic              vblank_irq;
	logic              render_line;
	logic              in_seen;

	assign line = m_axis_tdata[7:0];
	assign mode = m_axis_tdata[9:8];
	assign vblank_irq = m_axis_tdata[11];
	assign render_line = m_axis_tdata[13];
	assign in_seen = s_axis_tvalid & (s_axis_tdata != '0);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// the line stays inside the frame
	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> line < LINE_W'(TOTAL_LINES))
		else $error("line out of range");

	// vblank mode exactly on the lines past the visible area
	a_vbl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((line >= LINE_W'(VISIBLE_LINES)) == (mode == MODE_VBLANK)))
		else $error("mode does not follow line");

	// requests come with their mode
	a_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (vblank_irq || render_line) |->
		(vblank_irq && mode == MODE_VBLANK) || (render_line && mode == MODE_TRANSFER))
		else $error("entry request without its mode");

	// no result without an item in flight after reset
	a_noitem: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(s_axis_tvalid) && !$past(in_seen) && !$past(m_axis_tvalid) &&
		!$past(s_axis_tvalid, 2) && $past(arst_n, 2) |-> !m_axis_tvalid)
		else $error("result without an item");

endmodule

bind lcd_line_and_mode_timer lcdt_checker #(
	.TOTAL_LINES(TOTAL_LINES),
	.VISIBLE_LINES(VISIBLE_LINES)
) u_lcdt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata(s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
